### design/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared widths, packing layout and reset constants for the linear scan
// register allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

    localparam int ID_W      = 16;
    localparam int POS_W     = 16;
    localparam int CFG_W     = 4;
    localparam int RIDX_W    = 3;
    localparam int FREED_W   = 8;

    localparam int IN_W      = 48;
    localparam int OUT_USED  = ID_W + 1 + RIDX_W + 1 + ID_W + FREED_W;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_W - OUT_USED;

    localparam logic [CFG_W-1:0] REGS_EN_RESET = CFG_W'(8);

endpackage

### design/lsra_max_tree.sv
// ----------------------------------------------------------------------------
// lsra_max_tree
// Balanced compare tree that finds the candidate register with the greatest
// holder end, the lowest index winning ties.
// ----------------------------------------------------------------------------
module lsra_max_tree import lsra_pkg::*; #(
    parameter int N     = 8,
    parameter int IDX_W = 3
) (
    input  logic [N-1:0]     i_cand,
    input  logic [POS_W-1:0] i_end [N],
    output logic             o_found,
    output logic [IDX_W-1:0] o_idx
);

    localparam int LVLS  = $clog2(N);
    localparam int P     = 1 << LVLS;
    localparam int NODES = 2 * P - 1;

    logic             node_v [NODES];
    logic [POS_W-1:0] node_e [NODES];
    logic [IDX_W-1:0] node_i [NODES];

    genvar k;
    generate
        for (k = 0; k < P; k++) begin : g_leaf
            if (k < N) begin : g_used
                assign node_v[P-1+k] = i_cand[k];
                assign node_e[P-1+k] = i_end[k];
                assign node_i[P-1+k] = IDX_W'(k);
            end else begin : g_pad
                assign node_v[P-1+k] = 1'b0;
                assign node_e[P-1+k] = '0;
                assign node_i[P-1+k] = '0;
            end
        end

        for (k = 0; k < P - 1; k++) begin : g_node
            logic pick_r;
            assign pick_r = node_v[2*k+2] &&
                            (!node_v[2*k+1] || (node_e[2*k+2] > node_e[2*k+1]));
            assign node_v[k] = node_v[2*k+1] || node_v[2*k+2];
            assign node_e[k] = pick_r ? node_e[2*k+2] : node_e[2*k+1];
            assign node_i[k] = pick_r ? node_i[2*k+2] : node_i[2*k+1];
        end
    endgenerate

    assign o_found = node_v[0];
    assign o_idx   = node_i[0];

endmodule

### design/linear_scan_register_allocator.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator
// Assigns physical registers to live intervals in start order, expiring,
// allocating and spilling in one pass per interval.
// ----------------------------------------------------------------------------
// Usage:
//   Send one live interval per transaction on s_axis: tdata carries id,
//   start and end; tlast marks the last interval of a set, after which all
//   registers are released. Each interval yields one result on m_axis.
//   The cfg channel writes the number of usable registers (reset 8); write
//   it only while no interval is in flight. cfg_ready is always high.
//   An accepted interval passes the input register and then the result
//   register before it shows on m_axis. One interval is taken every cycle
//   while the output does not stall: expiry compares, the free-register
//   priority encoder and the greatest-end compare tree sit between the input
//   register and the result register, and the register file updates in the
//   same cycle, so the next interval sees it at once.
//   Reset: synchronous, active low; all registers free, both stages empty.
//   Stall: a held result waits in the result register while the input
//   register still accepts one more interval; s_axis_tready drops only when
//   both are full and m_axis_tready is low.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator import lsra_pkg::*; #(
    parameter int NUM_REGS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] interval_id, [31:16] start_pos, [47:32] end_pos
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [15:0] interval_echo, [16] got_register, [19:17] register_index,
    // [20] spill_valid, [36:21] spill_id, [44:37] freed_mask, [47:45] zero
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int PAD_W = (NUM_REGS > FREED_W) ? NUM_REGS : FREED_W;

    logic                r_in_valid;
    logic [ID_W-1:0]     r_in_id;
    logic [POS_W-1:0]    r_in_start;
    logic [POS_W-1:0]    r_in_end;
    logic                r_in_last;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic [NUM_REGS-1:0] r_busy;
    logic [ID_W-1:0]     r_hold_id  [NUM_REGS];
    logic [POS_W-1:0]    r_hold_end [NUM_REGS];
    logic [CFG_W-1:0]    r_regs_en;

    logic [NUM_REGS-1:0] n_busy;
    logic [OUT_W-1:0]    n_out_data;

    logic [NUM_REGS-1:0] expired;
    logic [NUM_REGS-1:0] busy_exp;
    logic [NUM_REGS-1:0] enabled;
    logic [NUM_REGS-1:0] cand;
    logic [PAD_W-1:0]    expired_pad;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                victim_found;
    logic [IDX_W-1:0]    victim_idx;
    logic                evict;
    logic                got;
    logic [IDX_W-1:0]    alloc_idx;
    logic [ID_W-1:0]     spill_id;
    logic                move;

    assign move          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || move;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        for (int r = 0; r < NUM_REGS; r++) begin
            expired[r]  = r_busy[r] && (r_hold_end[r] < r_in_start);
            busy_exp[r] = r_busy[r] && !expired[r];
            enabled[r]  = 6'(r) < {2'b00, r_regs_en};
            cand[r]     = busy_exp[r] && enabled[r];
        end
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int r = NUM_REGS - 1; r >= 0; r--) begin
            if (enabled[r] && !busy_exp[r]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(r);
            end
        end
    end

    lsra_max_tree #(
        .N     (NUM_REGS),
        .IDX_W (IDX_W)
    ) u_max_tree (
        .i_cand  (cand),
        .i_end   (r_hold_end),
        .o_found (victim_found),
        .o_idx   (victim_idx)
    );

    assign evict       = !free_found && victim_found &&
                         (r_hold_end[victim_idx] > r_in_end);
    assign got         = free_found || evict;
    assign alloc_idx   = free_found ? free_idx : victim_idx;
    assign spill_id    = evict ? r_hold_id[victim_idx] : r_in_id;
    assign expired_pad = PAD_W'(expired);

    always_comb begin
        n_out_data = {
            {OUT_PAD_W{1'b0}},
            expired_pad[FREED_W-1:0],
            free_found ? {ID_W{1'b0}} : spill_id,
            !free_found,
            got ? RIDX_W'(alloc_idx) : {RIDX_W{1'b0}},
            got,
            r_in_id
        };
        n_busy = busy_exp;
        if (got) begin
            n_busy = busy_exp | (NUM_REGS'(1) << alloc_idx);
        end
        if (r_in_last) begin
            n_busy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            r_regs_en   <= REGS_EN_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_busy      <= n_busy;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_regs_en <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_id    <= s_axis_tdata[ID_W-1:0];
            r_in_start <= s_axis_tdata[ID_W+POS_W-1:ID_W];
            r_in_end   <= s_axis_tdata[ID_W+2*POS_W-1:ID_W+POS_W];
            r_in_last  <= s_axis_tlast;
        end
        if (move) begin
            r_out_data <= n_out_data;
        end
        if (move && got) begin
            r_hold_id[alloc_idx]  <= r_in_id;
            r_hold_end[alloc_idx] <= r_in_end;
        end
    end

endmodule

### design/lsra_checker.sv
// ----------------------------------------------------------------------------
// lsra_assertions
// Port-level checks for the linear scan register allocator, bound to the
// top level.
// ----------------------------------------------------------------------------
module lsra_assertions import lsra_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    localparam int GOT_B   = ID_W;
    localparam int RIDX_LO = ID_W + 1;
    localparam int SPILL_B = RIDX_LO + RIDX_W;
    localparam int SID_LO  = SPILL_B + 1;

    logic                 got;
    logic                 spill;
    logic [RIDX_W-1:0]    ridx;
    logic [ID_W-1:0]      sid;
    logic [ID_W-1:0]      echo;

    assign echo  = m_axis_tdata[ID_W-1:0];
    assign got   = m_axis_tdata[GOT_B];
    assign ridx  = m_axis_tdata[SPILL_B-1:RIDX_LO];
    assign spill = m_axis_tdata[SPILL_B];
    assign sid   = m_axis_tdata[SID_LO+ID_W-1:SID_LO];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    a_self_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !got |-> spill && (sid == echo) && (ridx == '0))
        else $error("unallocated interval not reported as its own spill");

endmodule

bind linear_scan_register_allocator lsra_assertions u_lsra_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
